### design/mets_pkg.sv
// Shared types and constants of the Morse element timing sequencer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mets_pkg;

    // Field widths of the item and result ports
    localparam int PATTERN_W = 8;
    localparam int COUNT_W   = 4;
    localparam int TICK_W    = 16;
    localparam int RUN_W     = TICK_W + 2;

    // Default element limit and queue size between front and back
    localparam int MAX_ELEM_DEF = 8;
    localparam int QUEUE_DEPTH  = 2;

    // Configuration register map
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 4'd3;

    localparam logic [TICK_W-1:0] UNIT_RESET = 16'd1200;

    // Precomputed run lengths handed from the timing block to the back end
    typedef struct packed {
        logic [RUN_W-1:0] dot_down;   // dot key-down: tc + corr
        logic [RUN_W-1:0] gap_up;     // gap between elements: tc - corr
        logic [RUN_W-1:0] long_run;   // dash or character gap: 3 * tc
        logic [RUN_W-1:0] word_run;   // word space: 4 * tc
        logic             inv;        // line inversion
    } t_timing;

    // Values that follow from the reset configuration
    localparam t_timing TIMING_RESET = '{
        dot_down: 18'd1200,
        gap_up:   18'd1200,
        long_run: 18'd3600,
        word_run: 18'd4800,
        inv:      1'b0
    };

endpackage

`default_nettype wire

### design/mets_timing.sv
// Configuration registers and derived run lengths of the sequencer.
// Depends on mets_pkg.
`default_nettype none

module mets_timing (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mets_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mets_pkg::TICK_W-1:0]    i_cfg_data,
    output mets_pkg::t_timing                   o_timing
);
    import mets_pkg::*;

    logic [TICK_W-1:0]        r_unit;
    logic [TICK_W-1:0]        r_comp;
    logic [TICK_W-1:0]        r_corr;
    logic                     r_inv;
    t_timing                  r_timing;
    t_timing                  n_timing;

    logic [TICK_W-1:0]        tc;
    logic [TICK_W-2:0]        half;
    logic signed [TICK_W:0]   corr_x;
    logic signed [TICK_W:0]   half_s;
    logic signed [TICK_W:0]   corr_c;
    logic [RUN_W-1:0]         tc_x;
    logic [RUN_W-1:0]         corr_e;

    assign o_cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_RESET;
            r_comp <= '0;
            r_corr <= '0;
            r_inv  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UNIT:   r_unit <= i_cfg_data;
                CFG_COMP:   r_comp <= i_cfg_data;
                CFG_CORR:   r_corr <= i_cfg_data;
                CFG_INVERT: r_inv  <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Effective unit, then correction clamped to +/- half of it
    always_comb begin
        tc     = (r_comp < r_unit) ? (r_unit - r_comp) : r_unit;
        half   = tc[TICK_W-1:1];
        corr_x = {r_corr[TICK_W-1], r_corr};
        half_s = {2'b00, half};
        if (corr_x < -half_s) begin
            corr_c = -half_s;
        end else if (corr_x > half_s) begin
            corr_c = half_s;
        end else begin
            corr_c = corr_x;
        end
        tc_x   = {2'b00, tc};
        corr_e = {corr_c[TICK_W], corr_c};

        n_timing.dot_down = tc_x + corr_e;
        n_timing.gap_up   = tc_x - corr_e;
        n_timing.long_run = tc_x + {tc_x[RUN_W-2:0], 1'b0};
        n_timing.word_run = {tc, 2'b00};
        n_timing.inv      = r_inv;
    end

    // Derived lengths are registered from the written configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing <= TIMING_RESET;
        end else begin
            r_timing <= n_timing;
        end
    end

    assign o_timing = r_timing;

endmodule

`default_nettype wire

### design/mets_front.sv
// Front end: takes characters, saturates the element count and widens the
// pattern, then writes them into the queue. Depends on mets_pkg.
`default_nettype none

module mets_front #(
    parameter int MAX_ELEMENTS = mets_pkg::MAX_ELEM_DEF,
    parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [mets_pkg::PATTERN_W-1:0] i_element_pattern,
    input  wire logic [mets_pkg::COUNT_W-1:0]   i_element_count,
    input  wire logic                           i_q_full,
    output logic                                o_q_push,
    output logic [MAX_ELEMENTS+CNT_W-1:0]       o_q_data
);
    import mets_pkg::*;

    localparam int CMP_W = COUNT_W + 1;

    logic [CMP_W-1:0]        count_x;
    logic [CMP_W-1:0]        count_sat;
    logic [MAX_ELEMENTS-1:0] pattern;

    // Transfer whenever the queue has room
    assign o_stall  = i_q_full;
    assign o_q_push = i_valid && !i_q_full;

    // Counts above the element limit are cut to the limit
    always_comb begin
        count_x   = {1'b0, i_element_count};
        count_sat = (count_x > CMP_W'(MAX_ELEMENTS)) ? CMP_W'(MAX_ELEMENTS) : count_x;
    end

    // Elements past the pattern field are dots
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_pat
        if (g < PATTERN_W) begin : g_bit
            assign pattern[g] = i_element_pattern[g];
        end else begin : g_dot
            assign pattern[g] = 1'b0;
        end
    end

    assign o_q_data = {pattern, count_sat[CNT_W-1:0]};

endmodule

`default_nettype wire

### design/mets_queue.sv
// Short FIFO that decouples the front end from the run sequencer.
// Depends on mets_pkg for the default depth.
`default_nettype none

module mets_queue #(
    parameter int W     = 8,
    parameter int DEPTH = mets_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);
    import mets_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [LVL_W-1:0] r_level;

    assign o_full  = (r_level == LVL_W'(DEPTH));
    assign o_empty = (r_level == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/mets_back.sv
// Back end: walks one character's elements and emits one key-line run per
// cycle into the output register while it is not stalled. Depends on mets_pkg.
`default_nettype none

module mets_back #(
    parameter int MAX_ELEMENTS = mets_pkg::MAX_ELEM_DEF,
    parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [MAX_ELEMENTS+CNT_W-1:0]   i_q_data,
    input  wire logic                            i_q_empty,
    output logic                                 o_q_pop,
    input  mets_pkg::t_timing                    i_timing,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_key_level,
    output logic [mets_pkg::RUN_W-1:0]           o_run_ticks,
    output logic                                 o_last_run
);
    import mets_pkg::*;

    // Sequencer registers
    logic                    r_busy;
    logic [MAX_ELEMENTS-1:0] r_pat;
    logic [CNT_W-1:0]        r_left;
    logic                    r_up;
    logic                    r_word;

    // Output register
    logic                    r_valid;
    logic                    r_level;
    logic [RUN_W-1:0]        r_ticks;
    logic                    r_last;

    logic                    slot_free;
    logic                    emit;
    logic                    last_elem;
    logic                    last_emit;
    logic                    n_level;
    logic [RUN_W-1:0]        n_ticks;
    logic                    n_last;

    assign slot_free = !r_valid || !i_stall;
    assign emit      = r_busy && slot_free;
    assign last_elem = (r_left == CNT_W'(1));
    assign last_emit = emit && (r_word || (r_up && last_elem));
    assign o_q_pop   = !i_q_empty && (!r_busy || last_emit);

    // Run for the current element and phase
    always_comb begin
        if (r_word) begin
            n_level = i_timing.inv;
            n_ticks = i_timing.word_run;
            n_last  = 1'b1;
        end else if (!r_up) begin
            n_level = !i_timing.inv;
            n_ticks = r_pat[0] ? i_timing.long_run : i_timing.dot_down;
            n_last  = 1'b0;
        end else begin
            n_level = i_timing.inv;
            n_ticks = last_elem ? i_timing.long_run : i_timing.gap_up;
            n_last  = last_elem;
        end
    end

    // Element walk; a pop on the last run starts the next character at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            if (emit && !r_word) begin
                r_up <= !r_up;
                if (r_up) begin
                    r_pat  <= r_pat >> 1;
                    r_left <= r_left - 1'b1;
                end
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_pat  <= i_q_data[MAX_ELEMENTS+CNT_W-1:CNT_W];
                r_left <= i_q_data[CNT_W-1:0];
                r_up   <= 1'b0;
                r_word <= (i_q_data[CNT_W-1:0] == '0);
            end else if (last_emit) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (slot_free) begin
            r_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_level <= n_level;
            r_ticks <= n_ticks;
            r_last  <= n_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_key_level = r_level;
    assign o_run_ticks = r_ticks;
    assign o_last_run  = r_last;

endmodule

`default_nettype wire

### design/morse_element_timing_sequencer_unit.sv
// Top level of the Morse element timing sequencer.
// Depends on mets_pkg, mets_timing, mets_front, mets_queue and mets_back.
//
// Each character (dot/dash pattern plus element count) yields one key-down
// and one key-up run per element, or a single key-up word-space run for a
// count of zero. The sequencer emits one run per cycle while the output is
// not stalled, and the next character's first run follows the previous last
// run without a gap when that character is already queued. When the unit
// is idle, a character passes through the queue, the sequencer registers
// and the output register before its first run appears. A two-entry queue
// sits between the input and the sequencer, so up to two characters can be
// taken while an earlier one is still being sent. Run lengths follow
// configuration writes through the timing block's registers.
`default_nettype none

module morse_element_timing_sequencer_unit #(
    parameter int MAX_ELEMENTS = mets_pkg::MAX_ELEM_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // character input
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [mets_pkg::PATTERN_W-1:0] i_element_pattern,
    input  wire logic [mets_pkg::COUNT_W-1:0]   i_element_count,
    // run output
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_key_level,
    output logic [mets_pkg::RUN_W-1:0]          o_run_ticks,
    output logic                                o_last_run,
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mets_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mets_pkg::TICK_W-1:0]    i_cfg_data
);
    import mets_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int ENTRY_W = MAX_ELEMENTS + CNT_W;

    t_timing              timing;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    logic [ENTRY_W-1:0]   q_wdata;
    logic [ENTRY_W-1:0]   q_rdata;

    mets_timing u_timing (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_timing    (timing)
    );

    mets_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .CNT_W        (CNT_W)
    ) u_front (
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_element_pattern (i_element_pattern),
        .i_element_count   (i_element_count),
        .i_q_full          (q_full),
        .o_q_push          (q_push),
        .o_q_data          (q_wdata)
    );

    mets_queue #(
        .W     (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mets_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .CNT_W        (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_rdata),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_timing    (timing),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_key_level (o_key_level),
        .o_run_ticks (o_run_ticks),
        .o_last_run  (o_last_run)
    );

endmodule

`default_nettype wire

### design/mets_checker.sv
// Port-level assertions for the Morse element timing sequencer, and the
// bind that attaches them to the top level. Depends on mets_pkg.
`default_nettype none

module mets_props (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic                           o_stall,
    input  wire logic [mets_pkg::PATTERN_W-1:0] i_element_pattern,
    input  wire logic [mets_pkg::COUNT_W-1:0]   i_element_count,
    input  wire logic                           o_valid,
    input  wire logic                           i_stall,
    input  wire logic                           o_key_level,
    input  wire logic [mets_pkg::RUN_W-1:0]     o_run_ticks,
    input  wire logic                           o_last_run
);
    import mets_pkg::*;

    // A stalled character is held until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_element_pattern)
            && $stable(i_element_count))
        else $error("character changed while stalled");

    // A stalled run holds until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_key_level)
            && $stable(o_run_ticks) && $stable(o_last_run))
        else $error("run changed while stalled");

    // Runs of one character follow each other without a gap
    a_run_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_run |=> o_valid)
        else $error("character broken off before its last run");

    // Reset leaves no run pending
    a_rst_out: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("run pending after reset");

    // Reset leaves the queue empty, so input is taken at once
    a_rst_in: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_stall)
        else $error("input stalled after reset");

endmodule

bind morse_element_timing_sequencer_unit mets_props u_mets_props (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .i_element_pattern (i_element_pattern),
    .i_element_count   (i_element_count),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_key_level       (o_key_level),
    .o_run_ticks       (o_run_ticks),
    .o_last_run        (o_last_run)
);

`default_nettype wire
